/* design/rbfe_pkg.sv */
`default_nettype none

package rbfe_pkg;

   localparam int COORD_W  = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;
   localparam int PROD_W   = 32;
   localparam int SUM_W    = 35;
   localparam int DIST_W   = 22;
   localparam int SQ_W     = 2 * DIST_W;
   localparam int DIV_W    = 46;
   localparam int QUO_W    = 32;
   localparam int THICK_W  = 32;
   localparam int FRAC_SH  = 12;
   localparam logic [DIV_W-1:0] MIN_DIVISOR = DIV_W'(1);

   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_X_ROW        = 3'd0,
      REG_Y_ROW        = 3'd1,
      REG_Z_ROW        = 3'd2,
      REG_HALF_WIDTH   = 3'd3,
      REG_HALF_HEIGHT  = 3'd4,
      REG_HALF_LENGTH  = 3'd5,
      REG_THICKNESS_SQ = 3'd6
   } rbfe_reg_type;

   // Each row packs three Q4.12 coefficients and a Q8.8 offset, low bits first.
   typedef struct packed {
      logic [2:0][63:0]          row;
      logic [2:0][COORD_W-1:0]   half;
      logic [THICK_W-1:0]        thick;
   } rbfe_cfg_type;

   localparam logic [63:0] X_ROW_RESET = 64'd4096;
   localparam logic [63:0] Y_ROW_RESET = 64'd268435456;
   localparam logic [63:0] Z_ROW_RESET = 64'd17592186044416;
   localparam logic [COORD_W-1:0] HALF_RESET = 16'd256;
   localparam logic [THICK_W-1:0] THICK_RESET = 32'd65536;

endpackage

`default_nettype wire

/* design/rbfe_front.sv */
`default_nettype none

module rbfe_front import rbfe_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire rbfe_cfg_type              cfg,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [COORD_W-1:0] req_pos_x,
   input  wire logic signed [COORD_W-1:0] req_pos_y,
   input  wire logic signed [COORD_W-1:0] req_pos_z,
   output logic                           push_valid,
   input  wire logic                      push_ready,
   output logic [DIV_W-1:0]               push_div
);

   logic [4:0] valid_ff;
   logic       adv;

   logic signed [COORD_W-1:0] pos [3];
   logic signed [PROD_W-1:0]  prod_ff [3][3];
   logic signed [PROD_W-1:0]  prod_in [3][3];
   logic signed [SUM_W-1:0]   t_ff [3];
   logic signed [SUM_W-1:0]   t_in [3];
   logic [DIST_W-1:0]         dist_ff [3];
   logic [DIST_W-1:0]         dist_in [3];
   logic [SQ_W-1:0]           sq_ff [3];
   logic [SQ_W-1:0]           sq_in [3];
   logic [DIV_W-1:0]          div_ff;
   logic [DIV_W-1:0]          div_in;

   assign pos[0] = req_pos_x;
   assign pos[1] = req_pos_y;
   assign pos[2] = req_pos_z;

   assign adv        = !valid_ff[4] || push_ready;
   assign req_ready  = adv;
   assign push_valid = valid_ff[4];
   assign push_div   = div_ff;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic signed [SUM_W-1:0] off_ext;
      logic [SUM_W-1:0]        mag;
      logic [SUM_W-1:0]        lim;
      logic [SUM_W-1:0]        diff;

      for (genvar j = 0; j < 3; j++) begin : g_coef
         assign prod_in[a][j] = $signed(cfg.row[a][16*j +: 16]) * pos[j];
      end

      assign off_ext = SUM_W'($signed(cfg.row[a][63:48])) <<< FRAC_SH;
      assign t_in[a] = SUM_W'(prod_ff[a][0]) + SUM_W'(prod_ff[a][1])
                     + SUM_W'(prod_ff[a][2]) + off_ext;

      // Distance past the half extent, dropped to Q14.8 once it is positive.
      assign mag  = t_ff[a][SUM_W-1] ? SUM_W'(-t_ff[a]) : SUM_W'(t_ff[a]);
      assign lim  = {{(SUM_W-COORD_W-FRAC_SH){1'b0}}, cfg.half[a], {FRAC_SH{1'b0}}};
      assign diff = mag - lim;
      assign dist_in[a] = (mag > lim) ? diff[FRAC_SH +: DIST_W] : '0;

      assign sq_in[a] = SQ_W'(dist_ff[a]) * SQ_W'(dist_ff[a]);
   end

   assign div_in = DIV_W'(sq_ff[0]) + DIV_W'(sq_ff[1]) + DIV_W'(sq_ff[2]) + MIN_DIVISOR;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], req_valid};
      end
      if (adv) begin
         prod_ff <= prod_in;
         t_ff    <= t_in;
         dist_ff <= dist_in;
         sq_ff   <= sq_in;
         div_ff  <= div_in;
      end
   end

endmodule

`default_nettype wire

/* design/rbfe_queue.sv */
`default_nettype none

module rbfe_queue import rbfe_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [DIV_W-1:0] push_div,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [DIV_W-1:0]      pop_div
);

   logic [DIV_W-1:0]  data_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff;
   logic [QPTR_W-1:0] rd_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              push;
   logic              pop;

   assign push_ready = count_ff != QCNT_W'(QDEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_div    = data_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
      if (push) data_ff[wr_ff] <= push_div;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count past depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCNT_W'(QDEPTH)) |-> wr_ff == rd_ff)
      else $error("queue pointers disagree with count");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

endmodule

`default_nettype wire

/* design/rbfe_back.sv */
`default_nettype none

module rbfe_back import rbfe_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [THICK_W-1:0] thick,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   input  wire logic [DIV_W-1:0]   pop_div,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [QUO_W-1:0]        rsp_field_value
);

   localparam int NSTEP = QUO_W;

   logic [NSTEP:0]     valid_ff;
   logic [DIV_W-1:0]   div_ff [NSTEP+1];
   logic [DIV_W-1:0]   rem_ff [NSTEP+1];
   logic [QUO_W-1:0]   quo_ff [NSTEP+1];
   logic               sat_ff [NSTEP+1];
   logic [DIV_W-1:0]   rem_in [NSTEP+1];
   logic [QUO_W-1:0]   quo_in [NSTEP+1];
   logic [QUO_W-1:0]   num_lo;
   logic [DIV_W-1:0]   num_hi;
   logic               adv;

   // The numerator is thick * 2^16; its top 16 bits seed the remainder, and the
   // quotient overflows 32 bits exactly when they reach the divisor.
   assign num_hi = DIV_W'(thick[THICK_W-1:16]);
   assign num_lo = {thick[15:0], 16'h0000};

   assign adv             = !valid_ff[NSTEP] || rsp_ready;
   assign pop_ready       = adv;
   assign rsp_valid       = valid_ff[NSTEP];
   assign rsp_field_value = sat_ff[NSTEP] ? '1 : quo_ff[NSTEP];

   assign rem_in[0] = num_hi;
   assign quo_in[0] = '0;

   for (genvar k = 1; k <= NSTEP; k++) begin : g_step
      localparam int BitIdx = NSTEP - k;
      logic [DIV_W:0] sh;
      logic [DIV_W:0] sub;
      logic           ge;

      assign sh  = {rem_ff[k-1], num_lo[BitIdx]};
      assign ge  = sh >= {1'b0, div_ff[k-1]};
      assign sub = sh - {1'b0, div_ff[k-1]};
      assign rem_in[k] = ge ? sub[DIV_W-1:0] : sh[DIV_W-1:0];
      assign quo_in[k] = {quo_ff[k-1][QUO_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k] <= div_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[NSTEP-1:0], pop_valid};
      end
      if (adv) begin
         div_ff[0] <= pop_div;
         sat_ff[0] <= num_hi >= pop_div;
         rem_ff[0] <= rem_in[0];
         quo_ff[0] <= quo_in[0];
      end
   end

   a_sat_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && sat_ff[NSTEP]) |-> rsp_field_value == '1)
      else $error("saturated result not all ones");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NSTEP] && !rsp_ready) |=> valid_ff[NSTEP] && $stable(quo_ff[NSTEP]))
      else $error("divider advanced under a stalled result");

   a_no_pop_stall: assert property (@(posedge clock) disable iff (reset)
      (pop_valid && pop_ready) |=> valid_ff[0])
      else $error("popped divisor lost at divider entry");

endmodule

`default_nettype wire

/* design/rounded_box_field_eval.sv */
// Channel   Direction  Ports                               Beat
// req       in         req_valid/ready, req_pos_x/y/z      one sample point
// rsp       out        rsp_valid/ready, rsp_field_value    one Q16.16 field value
// csr       in         csr_valid/ready, csr_index/data     one register write
//
// One point is taken per cycle while the front is not held by a full queue; its
// result passes five front stages, one queue slot, a divider entry stage and 32
// divider stages of one quotient bit each.
// Reset is synchronous and restores the identity transform and unit extents.
// The four-entry queue lets the front keep taking points while the divider
// holds a stalled result, until the queue fills; csr_ready is always high.
`default_nettype none

module rounded_box_field_eval import rbfe_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COORD_W-1:0]    req_pos_x,
   input  wire logic signed [COORD_W-1:0]    req_pos_y,
   input  wire logic signed [COORD_W-1:0]    req_pos_z,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [QUO_W-1:0]                  rsp_field_value,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_data
);

   rbfe_cfg_type     cfg_ff;
   logic             push_valid;
   logic             push_ready;
   logic [DIV_W-1:0] push_div;
   logic             pop_valid;
   logic             pop_ready;
   logic [DIV_W-1:0] pop_div;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row[0] <= X_ROW_RESET;
         cfg_ff.row[1] <= Y_ROW_RESET;
         cfg_ff.row[2] <= Z_ROW_RESET;
         cfg_ff.half   <= {HALF_RESET, HALF_RESET, HALF_RESET};
         cfg_ff.thick  <= THICK_RESET;
      end else if (csr_valid) begin
         unique case (rbfe_reg_type'(csr_index))
            REG_X_ROW:        cfg_ff.row[0]  <= csr_data;
            REG_Y_ROW:        cfg_ff.row[1]  <= csr_data;
            REG_Z_ROW:        cfg_ff.row[2]  <= csr_data;
            REG_HALF_WIDTH:   cfg_ff.half[0] <= csr_data[COORD_W-1:0];
            REG_HALF_HEIGHT:  cfg_ff.half[1] <= csr_data[COORD_W-1:0];
            REG_HALF_LENGTH:  cfg_ff.half[2] <= csr_data[COORD_W-1:0];
            REG_THICKNESS_SQ: cfg_ff.thick   <= csr_data[THICK_W-1:0];
            default: ;
         endcase
      end
   end

   rbfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .req_pos_z  (req_pos_z),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_div   (push_div)
   );

   rbfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_div   (push_div),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_div    (pop_div)
   );

   rbfe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .thick           (cfg_ff.thick),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_div         (pop_div),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_field_value (rsp_field_value)
   );

endmodule

`default_nettype wire
